[design/lcd_window_pixel_byte_sequencer_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the LCD window pixel byte sequencer
// Shared concurrent check forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LCD_WINDOW_PIXEL_BYTE_SEQUENCER_MACROS_SVH
`define LCD_WINDOW_PIXEL_BYTE_SEQUENCER_MACROS_SVH

// same-cycle implication
`define LCDWS_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCDWS_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lcdws_pkg.sv]
// ---------------------------------------------------------------------------
// lcdws_pkg
// Types and constants shared by the LCD window pixel byte sequencer.
// ---------------------------------------------------------------------------
package lcdws_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [15:0] WIDTH_RESET  = 16'd320;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;

    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_OFFSET_X = 2'd2;
    localparam logic [1:0] REG_OFFSET_Y = 2'd3;

    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_RECT  = 2'd1;
    localparam logic [1:0] KIND_PIXEL = 2'd2;

    localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
    localparam logic [7:0] CMD_PAGE_SET   = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;

    // byte positions in the full point sequence
    localparam logic [3:0] POS_COL_CMD = 4'd0;
    localparam logic [3:0] POS_XA_HI   = 4'd1;
    localparam logic [3:0] POS_XA_LO   = 4'd2;
    localparam logic [3:0] POS_XB_HI   = 4'd3;
    localparam logic [3:0] POS_XB_LO   = 4'd4;
    localparam logic [3:0] POS_PAGE    = 4'd5;
    localparam logic [3:0] POS_YA_HI   = 4'd6;
    localparam logic [3:0] POS_YA_LO   = 4'd7;
    localparam logic [3:0] POS_YB_HI   = 4'd8;
    localparam logic [3:0] POS_YB_LO   = 4'd9;
    localparam logic [3:0] POS_MEMWR   = 4'd10;
    localparam logic [3:0] POS_RED     = 4'd11;
    localparam logic [3:0] POS_GREEN   = 4'd12;
    localparam logic [3:0] POS_BLUE    = 4'd13;

    typedef enum logic [1:0] {
        OP_WIN_PIX,
        OP_WIN,
        OP_PIX
    } op_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] x_start;
        logic [15:0] y_start;
        logic [15:0] x_end;
        logic [15:0] y_end;
        logic [15:0] color;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last;
    } rsp_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] xa;
        logic [15:0] xb;
        logic [15:0] ya;
        logic [15:0] yb;
        logic [15:0] color;
    } desc_t;

endpackage

[design/lcd_window_pixel_byte_sequencer.sv]
// ---------------------------------------------------------------------------
// lcd_window_pixel_byte_sequencer
// Turns point, rectangle and pixel requests into display command and data
// bytes, with the window clipped to the panel and shifted by the offsets.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_t
//   rsp       out        rsp_valid/rsp_ready  rsp_t, one byte per item
//   cfg       in         cfg_we               cfg_index, cfg_data
//
// One byte leaves per cycle unless the output stalls: a pixel makes 3 bytes, a
// rectangle 11, a point 14; the back end byte counter sets this. The
// descriptor queue lets the front accept while bytes drain.
// Reset is asynchronous; panel size resets to 320 by 480, offsets to 0.
// ---------------------------------------------------------------------------
module lcd_window_pixel_byte_sequencer
    import lcdws_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp
);

    logic  q_ready;
    logic  q_push;
    desc_t q_desc;
    logic  q_pop;
    logic  head_valid;
    desc_t head;

    lcdws_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_desc    (q_desc)
    );

    lcdws_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_desc  (q_desc),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    lcdws_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (q_pop),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

[design/lcdws_front.sv]
// ---------------------------------------------------------------------------
// lcdws_front
// Holds the panel registers, checks points and rectangles, clips rectangles
// and builds the window coordinates that the back end turns into bytes.
// ---------------------------------------------------------------------------
module lcdws_front
    import lcdws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    input  logic        q_ready,
    output logic        q_push,
    output desc_t       q_desc
);

    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [15:0] offset_x_reg;
    logic [15:0] offset_y_reg;

    logic        reject;
    logic        push_ok;
    logic [15:0] x_end_clip;
    logic [15:0] y_end_clip;
    logic [15:0] xa;
    logic [15:0] ya;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:    width_reg    <= cfg_data;
                REG_HEIGHT:   height_reg   <= cfg_data;
                REG_OFFSET_X: offset_x_reg <= cfg_data;
                REG_OFFSET_Y: offset_y_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        reject     = (req.x_start >= width_reg) || (req.y_start >= height_reg);
        x_end_clip = (req.x_end >= width_reg)  ? width_reg - 16'd1  : req.x_end;
        y_end_clip = (req.y_end >= height_reg) ? height_reg - 16'd1 : req.y_end;
        xa         = req.x_start + offset_x_reg;
        ya         = req.y_start + offset_y_reg;

        q_desc.op    = OP_PIX;
        q_desc.xa    = xa;
        q_desc.ya    = ya;
        q_desc.xb    = x_end_clip + offset_x_reg;
        q_desc.yb    = y_end_clip + offset_y_reg;
        q_desc.color = req.color;
        push_ok      = 1'b0;

        unique case (req.kind)
            KIND_POINT:
            begin
                q_desc.op = OP_WIN_PIX;
                q_desc.xb = xa;
                q_desc.yb = ya;
                push_ok   = !reject;
            end
            KIND_RECT:
            begin
                q_desc.op = OP_WIN;
                push_ok   = !reject;
            end
            KIND_PIXEL:
            begin
                q_desc.op = OP_PIX;
                push_ok   = 1'b1;
            end
            default:
            begin
                push_ok = 1'b0;
            end
        endcase
    end

    // rejected and unused kinds are taken and dropped
    assign req_ready = q_ready;
    assign q_push    = req_valid && q_ready && push_ok;

endmodule

[design/lcdws_queue.sv]
// ---------------------------------------------------------------------------
// lcdws_queue
// Small FIFO of request descriptors between front and back end.
// ---------------------------------------------------------------------------
module lcdws_queue
    import lcdws_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    output logic  push_ready,
    input  logic  pop,
    output logic  head_valid,
    output desc_t head
);

`include "lcd_window_pixel_byte_sequencer_macros.svh"

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    desc_t           mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign push_ready = (count_reg != CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    `LCDWS_CHECK(a_no_underflow, pop, count_reg != '0, "queue pop while empty")
    `LCDWS_CHECK(a_no_overflow, push, count_reg != CW'(DEPTH), "queue push while full")

endmodule

[design/lcdws_back.sv]
// ---------------------------------------------------------------------------
// lcdws_back
// Walks the head descriptor into a registered output, one byte per cycle unless stalled.
// ---------------------------------------------------------------------------
module lcdws_back
    import lcdws_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  head_valid,
    input  desc_t head,
    output logic  pop,
    output logic  rsp_valid,
    input  logic  rsp_ready,
    output rsp_t  rsp
);

`include "lcd_window_pixel_byte_sequencer_macros.svh"

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic       busy_reg;
    logic       busy_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    rsp_t       rsp_reg;
    rsp_t       rsp_next;

    logic [3:0] pos;
    logic       advance;

    always_comb
    begin
        pos     = busy_reg ? pos_reg : ((head.op == OP_PIX) ? POS_RED : POS_COL_CMD);
        advance = head_valid && (!rsp_valid_reg || rsp_ready);

        rsp_next.is_data = 1'b1;
        case (pos)
            POS_COL_CMD: begin rsp_next.out_byte = CMD_COLUMN_SET; rsp_next.is_data = 1'b0; end
            POS_XA_HI:   rsp_next.out_byte = head.xa[15:8];
            POS_XA_LO:   rsp_next.out_byte = head.xa[7:0];
            POS_XB_HI:   rsp_next.out_byte = head.xb[15:8];
            POS_XB_LO:   rsp_next.out_byte = head.xb[7:0];
            POS_PAGE:    begin rsp_next.out_byte = CMD_PAGE_SET; rsp_next.is_data = 1'b0; end
            POS_YA_HI:   rsp_next.out_byte = head.ya[15:8];
            POS_YA_LO:   rsp_next.out_byte = head.ya[7:0];
            POS_YB_HI:   rsp_next.out_byte = head.yb[15:8];
            POS_YB_LO:   rsp_next.out_byte = head.yb[7:0];
            POS_MEMWR:   begin rsp_next.out_byte = CMD_MEM_WRITE; rsp_next.is_data = 1'b0; end
            POS_RED:     rsp_next.out_byte = {head.color[15:11], 3'b000};
            POS_GREEN:   rsp_next.out_byte = {head.color[10:5], 2'b00};
            POS_BLUE:    rsp_next.out_byte = {head.color[4:0], 3'b000};
            default:     rsp_next.out_byte = '0;
        endcase
        rsp_next.last = (pos == POS_BLUE) || ((pos == POS_MEMWR) && (head.op == OP_WIN));

        pop       = advance && rsp_next.last;
        pos_next  = pos_reg;
        busy_next = busy_reg;
        if (advance)
        begin
            pos_next  = pos + 4'd1;
            busy_next = !rsp_next.last;
        end

        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            busy_reg      <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `LCDWS_CHECK(a_busy_has_head, busy_reg, head_valid, "sequencing without a descriptor")
    `LCDWS_CHECK_NEXT(a_pop_sends_last, pop, rsp_valid_reg && rsp_reg.last,
        "descriptor retired without a last byte")

endmodule
